// ===== rtl/core/ptd_pkg.sv =====
// shared types and constants of the periodic task dispatcher
// used by ptd_due_unit and periodic_task_dispatcher_core, no dependencies
package ptd_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 8;
  localparam int unsigned TOP_LEVEL_DEF = 5;
  localparam int unsigned MAX_RESULTS   = 8;
  localparam int unsigned NRES_W        = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] CMD_RUN     = 2'd0;
  localparam logic [1:0] CMD_ADD     = 2'd1;
  localparam logic [1:0] CMD_ENABLE  = 2'd2;
  localparam logic [1:0] CMD_DISABLE = 2'd3;

  localparam logic [1:0] KIND_ADD      = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_NONE_DUE = 2'd2;
  localparam logic [1:0] KIND_ENA_DONE = 2'd3;

  typedef struct packed {
    logic        due_hit;
    logic [31:0] next_due;
    logic [31:0] next_runs;
  } due_res_t;

endpackage

// ===== rtl/core/periodic_task_dispatcher_core.sv =====
// periodic task dispatcher top level: task table, scan sequencer, result register
// depends on ptd_pkg and ptd_due_unit
//
// usage
//   input beat: accepted at a rising edge with start high and busy low
//   in_cmd selects run pass, add task, enable task or disable task
//   add, enable and disable never raise busy; their single result beat shows
//   on the out_ ports with out_strobe in the cycle after the accept
//   a run pass raises busy while it checks every slot at every priority
//   level, highest first, through the shared due-check unit, then the flush
//   state; the next command is taken once busy falls, and the final beat
//   shows in the cycle after the flush
//   a dispatch beat is held back until the next hit of the pass or the flush
//   cycle shows whether it is the last, and shows in the cycle after that
//   a pass with nothing due gives one nothing-due beat
//   each result beat is on the ports for exactly one cycle; the receiver
//   cannot stall, so no backpressure exists
//   reset clears the task count, the enable bits and the sequencer; table
//   contents stay undefined until an add writes them
module periodic_task_dispatcher_core #(
  parameter int unsigned MAX_SLOTS = ptd_pkg::MAX_SLOTS_DEF,
  parameter int unsigned TOP_LEVEL = ptd_pkg::TOP_LEVEL_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_current_tick,
  input  logic [31:0] in_period,
  input  logic [2:0]  in_priority_req,
  input  logic [7:0]  in_task_id,
  output logic        out_strobe,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_slot,
  output logic        out_accepted,
  output logic [31:0] out_runs,
  output logic        out_last
);

  localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  // task table
  logic [31:0]          period_r [MAX_SLOTS];
  logic [31:0]          due_r    [MAX_SLOTS];
  logic [2:0]           prio_r   [MAX_SLOTS];
  logic [31:0]          runs_r   [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] en_r, en_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  // sequencer
  state_t                    state_r, state_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [2:0]                lvl_r, lvl_nxt;
  logic [ptd_pkg::NRES_W-1:0] n_r, n_nxt;
  logic [31:0]               tick_r, tick_nxt;

  // held-back dispatch beat
  logic        pend_vld_r, pend_vld_nxt;
  logic [2:0]  pend_slot_r, pend_slot_nxt;
  logic [31:0] pend_runs_r, pend_runs_nxt;

  // result register
  logic        strobe_r, strobe_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [2:0]  slot_r, slot_nxt;
  logic        acc_r, acc_nxt;
  logic [31:0] oruns_r, oruns_nxt;
  logic        last_r, last_nxt;

  ptd_pkg::due_res_t due_res;
  logic              accept;
  logic              hit;
  logic              last_step;
  logic              add_wr;
  logic              disp_wr;
  logic [IDX_W-1:0]  add_idx;

  ptd_due_unit u_due (
    .tick   (tick_r),
    .due    (due_r[idx_r]),
    .period (period_r[idx_r]),
    .runs   (runs_r[idx_r]),
    .res    (due_res)
  );

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign add_idx = count_r[IDX_W-1:0];

  // one slot check per cycle: registered, enabled, on this level, due, under the cap
  assign hit = (state_r == ST_SCAN) &&
               (CNT_W'(idx_r) < count_r) &&
               en_r[idx_r] &&
               (prio_r[idx_r] == lvl_r) &&
               due_res.due_hit &&
               (n_r < ptd_pkg::NRES_W'(ptd_pkg::MAX_RESULTS));

  assign last_step = (idx_r == IDX_W'(MAX_SLOTS - 1)) && (lvl_r == 3'd0);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    lvl_nxt       = lvl_r;
    n_nxt         = n_r;
    tick_nxt      = tick_r;
    pend_vld_nxt  = pend_vld_r;
    pend_slot_nxt = pend_slot_r;
    pend_runs_nxt = pend_runs_r;
    en_nxt        = en_r;
    count_nxt     = count_r;
    add_wr        = 1'b0;
    disp_wr       = 1'b0;
    strobe_nxt    = 1'b0;
    kind_nxt      = kind_r;
    slot_nxt      = slot_r;
    acc_nxt       = acc_r;
    oruns_nxt     = oruns_r;
    last_nxt      = last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            ptd_pkg::CMD_ADD: begin
              strobe_nxt = 1'b1;
              kind_nxt   = ptd_pkg::KIND_ADD;
              oruns_nxt  = 32'd0;
              last_nxt   = 1'b1;
              if (count_r == CNT_W'(MAX_SLOTS)) begin
                slot_nxt = 3'd0;
                acc_nxt  = 1'b0;
              end else begin
                add_wr           = 1'b1;
                en_nxt[add_idx]  = 1'b1;
                count_nxt        = count_r + CNT_W'(1);
                slot_nxt         = 3'(count_r);
                acc_nxt          = 1'b1;
              end
            end
            ptd_pkg::CMD_ENABLE, ptd_pkg::CMD_DISABLE: begin
              strobe_nxt = 1'b1;
              kind_nxt   = ptd_pkg::KIND_ENA_DONE;
              oruns_nxt  = 32'd0;
              last_nxt   = 1'b1;
              if (in_task_id < 8'(count_r)) begin
                en_nxt[in_task_id[IDX_W-1:0]] = (in_cmd == ptd_pkg::CMD_ENABLE);
                slot_nxt = 3'(in_task_id);
                acc_nxt  = 1'b1;
              end else begin
                slot_nxt = 3'd0;
                acc_nxt  = 1'b0;
              end
            end
            ptd_pkg::CMD_RUN: begin
              state_nxt    = ST_SCAN;
              tick_nxt     = in_current_tick;
              idx_nxt      = '0;
              lvl_nxt      = 3'(TOP_LEVEL);
              n_nxt        = '0;
              pend_vld_nxt = 1'b0;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (hit) begin
          disp_wr = 1'b1;
          n_nxt   = n_r + ptd_pkg::NRES_W'(1);
          // a newer dispatch shows the held one was not the last
          if (pend_vld_r) begin
            strobe_nxt = 1'b1;
            kind_nxt   = ptd_pkg::KIND_DISPATCH;
            slot_nxt   = pend_slot_r;
            acc_nxt    = 1'b1;
            oruns_nxt  = pend_runs_r;
            last_nxt   = 1'b0;
          end
          pend_vld_nxt  = 1'b1;
          pend_slot_nxt = 3'(idx_r);
          pend_runs_nxt = due_res.next_runs;
        end
        if (last_step) begin
          state_nxt = ST_FLUSH;
        end else if (idx_r == IDX_W'(MAX_SLOTS - 1)) begin
          idx_nxt = '0;
          lvl_nxt = lvl_r - 3'd1;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      ST_FLUSH: begin
        state_nxt  = ST_IDLE;
        strobe_nxt = 1'b1;
        last_nxt   = 1'b1;
        if (pend_vld_r) begin
          kind_nxt  = ptd_pkg::KIND_DISPATCH;
          slot_nxt  = pend_slot_r;
          acc_nxt   = 1'b1;
          oruns_nxt = pend_runs_r;
        end else begin
          kind_nxt  = ptd_pkg::KIND_NONE_DUE;
          slot_nxt  = 3'd0;
          acc_nxt   = 1'b0;
          oruns_nxt = 32'd0;
        end
        pend_vld_nxt = 1'b0;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      en_r       <= '0;
      count_r    <= '0;
      pend_vld_r <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      en_r       <= en_nxt;
      count_r    <= count_nxt;
      pend_vld_r <= pend_vld_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    lvl_r       <= lvl_nxt;
    n_r         <= n_nxt;
    tick_r      <= tick_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_runs_r <= pend_runs_nxt;
    kind_r      <= kind_nxt;
    slot_r      <= slot_nxt;
    acc_r       <= acc_nxt;
    oruns_r     <= oruns_nxt;
    last_r      <= last_nxt;
  end

  // table writes: add at the fill index, dispatch at the scan index
  always_ff @(posedge clk) begin
    if (add_wr) begin
      period_r[add_idx] <= in_period;
      due_r[add_idx]    <= in_period;
      prio_r[add_idx]   <= in_priority_req;
      runs_r[add_idx]   <= 32'd0;
    end
    if (disp_wr) begin
      due_r[idx_r]  <= due_res.next_due;
      runs_r[idx_r] <= due_res.next_runs;
    end
  end

  assign out_strobe   = strobe_r;
  assign out_kind     = kind_r;
  assign out_slot     = slot_r;
  assign out_accepted = acc_r;
  assign out_runs     = oruns_r;
  assign out_last     = last_r;

endmodule

// ===== rtl/core/ptd_due_unit.sv =====
// shared due-check unit: unsigned tick compare, next-due add, run count bump
// depends on ptd_pkg for the result struct
module ptd_due_unit (
  input  logic [31:0]       tick,
  input  logic [31:0]       due,
  input  logic [31:0]       period,
  input  logic [31:0]       runs,
  output ptd_pkg::due_res_t res
);

  always_comb begin
    res.due_hit   = (tick >= due);
    res.next_due  = tick + period;   // wraps
    res.next_runs = runs + 32'd1;    // wraps
  end

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for periodic_task_dispatcher_core
// depends on ptd_pkg and the dispatcher rtl; a directed table runs first, random commands follow
// every result beat is checked against an in-bench model of the task table or a typed-in result
module tb_top;

  localparam int SLOTS          = ptd_pkg::MAX_SLOTS_DEF;
  localparam int TOP_PRIO       = ptd_pkg::TOP_LEVEL_DEF;
  localparam int RAND_PER_PHASE = 54;
  localparam int STALL_LIMIT    = 600;
  // a run pass keeps busy high for less than this, so it covers any tail
  localparam int TAIL_CYCLES    = 64;

  // one result beat as the block presents it
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic        accepted;
    logic [31:0] runs;
    logic        last;
  } beat_t;

  // one command beat, with an optional typed-in result
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] tick;
    logic [31:0] period;
    logic [2:0]  prio;
    logic [7:0]  id;
    logic        typed;
    beat_t       want;
  } stim_row_t;

  localparam beat_t NO_BEAT = '0;

  // directed table: unregistered ids on an empty table, one add per priority
  // level, table full, wrapped due times, enable and disable of valid and
  // invalid ids; typed results only where they are obvious
  localparam stim_row_t DIRECTED [22] = '{
    '{ptd_pkg::CMD_RUN, 32'd0, 32'hFFFF_FFFF, 3'd7, 8'd255, 1'b1,
      '{ptd_pkg::KIND_NONE_DUE, 3'd0, 1'b0, 32'd0, 1'b1}},
    '{ptd_pkg::CMD_ENABLE, 32'd0, 32'd0, 3'd0, 8'd0, 1'b1,
      '{ptd_pkg::KIND_ENA_DONE, 3'd0, 1'b0, 32'd0, 1'b1}},
    '{ptd_pkg::CMD_DISABLE, 32'd0, 32'd0, 3'd0, 8'd255, 1'b1,
      '{ptd_pkg::KIND_ENA_DONE, 3'd0, 1'b0, 32'd0, 1'b1}},
    '{ptd_pkg::CMD_ADD, 32'd0, 32'd0, 3'd5, 8'd0, 1'b1,
      '{ptd_pkg::KIND_ADD, 3'd0, 1'b1, 32'd0, 1'b1}},
    '{ptd_pkg::CMD_ADD, 32'd0, 32'hFFFF_FFFF, 3'd0, 8'd0, 1'b1,
      '{ptd_pkg::KIND_ADD, 3'd1, 1'b1, 32'd0, 1'b1}},
    '{ptd_pkg::CMD_ADD, 32'd0, 32'd10, 3'd7, 8'd0, 1'b1,
      '{ptd_pkg::KIND_ADD, 3'd2, 1'b1, 32'd0, 1'b1}},
    '{ptd_pkg::CMD_ADD, 32'd0, 32'd5, 3'd6, 8'd0, 1'b1,
      '{ptd_pkg::KIND_ADD, 3'd3, 1'b1, 32'd0, 1'b1}},
    '{ptd_pkg::CMD_ADD, 32'd0, 32'd3, 3'd3, 8'd0, 1'b1,
      '{ptd_pkg::KIND_ADD, 3'd4, 1'b1, 32'd0, 1'b1}},
    '{ptd_pkg::CMD_ADD, 32'd0, 32'd100, 3'd4, 8'd0, 1'b1,
      '{ptd_pkg::KIND_ADD, 3'd5, 1'b1, 32'd0, 1'b1}},
    '{ptd_pkg::CMD_ADD, 32'd0, 32'd1, 3'd1, 8'd0, 1'b1,
      '{ptd_pkg::KIND_ADD, 3'd6, 1'b1, 32'd0, 1'b1}},
    '{ptd_pkg::CMD_ADD, 32'd0, 32'd0, 3'd2, 8'd0, 1'b1,
      '{ptd_pkg::KIND_ADD, 3'd7, 1'b1, 32'd0, 1'b1}},
    // table full
    '{ptd_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 8'd255, 1'b1,
      '{ptd_pkg::KIND_ADD, 3'd0, 1'b0, 32'd0, 1'b1}},
    '{ptd_pkg::CMD_RUN, 32'd0, 32'd0, 3'd0, 8'd0, 1'b0, NO_BEAT},
    '{ptd_pkg::CMD_RUN, 32'hFFFF_FFFF, 32'd0, 3'd0, 8'd0, 1'b0, NO_BEAT},
    '{ptd_pkg::CMD_DISABLE, 32'd0, 32'd0, 3'd0, 8'd0, 1'b1,
      '{ptd_pkg::KIND_ENA_DONE, 3'd0, 1'b1, 32'd0, 1'b1}},
    '{ptd_pkg::CMD_DISABLE, 32'd0, 32'd0, 3'd0, 8'd8, 1'b1,
      '{ptd_pkg::KIND_ENA_DONE, 3'd0, 1'b0, 32'd0, 1'b1}},
    '{ptd_pkg::CMD_RUN, 32'hFFFF_FFFF, 32'd0, 3'd0, 8'd0, 1'b0, NO_BEAT},
    '{ptd_pkg::CMD_ENABLE, 32'd0, 32'd0, 3'd0, 8'd7, 1'b1,
      '{ptd_pkg::KIND_ENA_DONE, 3'd7, 1'b1, 32'd0, 1'b1}},
    '{ptd_pkg::CMD_ENABLE, 32'd0, 32'd0, 3'd0, 8'd0, 1'b1,
      '{ptd_pkg::KIND_ENA_DONE, 3'd0, 1'b1, 32'd0, 1'b1}},
    '{ptd_pkg::CMD_DISABLE, 32'd0, 32'd0, 3'd0, 8'd5, 1'b1,
      '{ptd_pkg::KIND_ENA_DONE, 3'd5, 1'b1, 32'd0, 1'b1}},
    '{ptd_pkg::CMD_RUN, 32'h8000_0000, 32'd0, 3'd0, 8'd0, 1'b0, NO_BEAT},
    '{ptd_pkg::CMD_RUN, 32'h8000_0000, 32'd0, 3'd0, 8'd0, 1'b0, NO_BEAT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = ptd_pkg::CMD_RUN;
  logic [31:0] in_current_tick = '0;
  logic [31:0] in_period = '0;
  logic [2:0]  in_priority_req = '0;
  logic [7:0]  in_task_id = '0;
  logic        out_strobe;
  logic [1:0]  out_kind;
  logic [2:0]  out_slot;
  logic        out_accepted;
  logic [31:0] out_runs;
  logic        out_last;

  // model of the task table
  logic [31:0] sched_period [SLOTS];
  logic [31:0] sched_due    [SLOTS];
  logic [31:0] sched_runs   [SLOTS];
  logic [2:0]  sched_prio   [SLOTS];
  logic        sched_en     [SLOTS];
  int unsigned sched_count = 0;

  beat_t       step_beats[$];      // beats caused by the command just accepted
  beat_t       pending_beats[$];   // beats still owed by the block
  int          idle_pct = 0;
  int          err_cnt = 0;
  int          stall_cycles = 0;
  logic [31:0] cur_tick = 32'h8000_0000;

  periodic_task_dispatcher_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_current_tick (in_current_tick),
    .in_period       (in_period),
    .in_priority_req (in_priority_req),
    .in_task_id      (in_task_id),
    .out_strobe      (out_strobe),
    .out_kind        (out_kind),
    .out_slot        (out_slot),
    .out_accepted    (out_accepted),
    .out_runs        (out_runs),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  initial begin
    foreach (sched_en[i]) sched_en[i] = 1'b0;
  end

  // apply one command to the table model, leaving its beats in step_beats
  function automatic void dispatch_step(input stim_row_t row);
    beat_t b;
    beat_t d;
    step_beats.delete();
    b = '0;
    b.last = 1'b1;
    case (row.cmd)
      ptd_pkg::CMD_ADD: begin
        b.kind = ptd_pkg::KIND_ADD;
        if (sched_count < SLOTS) begin
          sched_period[sched_count] = row.period;
          sched_due[sched_count]    = row.period;
          sched_prio[sched_count]   = row.prio;
          sched_runs[sched_count]   = '0;
          sched_en[sched_count]     = 1'b1;
          b.slot     = 3'(sched_count);
          b.accepted = 1'b1;
          sched_count++;
        end
        step_beats.push_back(b);
      end
      ptd_pkg::CMD_ENABLE, ptd_pkg::CMD_DISABLE: begin
        b.kind = ptd_pkg::KIND_ENA_DONE;
        if (row.id < sched_count) begin
          sched_en[row.id] = (row.cmd == ptd_pkg::CMD_ENABLE);
          b.slot     = row.id[2:0];
          b.accepted = 1'b1;
        end
        step_beats.push_back(b);
      end
      default: begin
        // run pass: highest level first, index order within a level
        for (int lvl = TOP_PRIO; lvl >= 0; lvl--) begin
          for (int i = 0; i < sched_count; i++) begin
            if (sched_en[i] && sched_prio[i] == 3'(lvl) && row.tick >= sched_due[i] &&
                step_beats.size() < ptd_pkg::MAX_RESULTS) begin
              sched_runs[i] = sched_runs[i] + 32'd1;
              sched_due[i]  = row.tick + sched_period[i];
              d = '0;
              d.kind     = ptd_pkg::KIND_DISPATCH;
              d.slot     = 3'(i);
              d.accepted = 1'b1;
              d.runs     = sched_runs[i];
              step_beats.push_back(d);
            end
          end
        end
        if (step_beats.size() == 0) begin
          b.kind = ptd_pkg::KIND_NONE_DUE;
          step_beats.push_back(b);
        end else begin
          step_beats[step_beats.size() - 1].last = 1'b1;
        end
      end
    endcase
  endfunction

  // random command, weighted toward run passes near the due times
  function automatic stim_row_t random_row();
    stim_row_t row;
    int        r;
    row = '0;
    row.period = $urandom;
    row.prio   = 3'($urandom_range(0, 7));
    row.id     = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 9)) : 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 62) begin
      row.cmd = ptd_pkg::CMD_RUN;
      r = $urandom_range(0, 99);
      if (r < 80) cur_tick = cur_tick + 32'($urandom_range(0, 12));
      else if (r < 90) cur_tick = $urandom;
      else cur_tick = cur_tick + 32'($urandom_range(0, 200));
      row.tick = cur_tick;
    end else begin
      row.tick = $urandom;
      if (r < 82) row.cmd = ptd_pkg::CMD_ENABLE;
      else if (r < 94) row.cmd = ptd_pkg::CMD_DISABLE;
      else row.cmd = ptd_pkg::CMD_ADD;
    end
    return row;
  endfunction

  // drive one command beat, hold it until accepted, then log what it owes
  task automatic issue_cmd(input stim_row_t row);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_cmd          <= row.cmd;
    in_current_tick <= row.tick;
    in_period       <= row.period;
    in_priority_req <= row.prio;
    in_task_id      <= row.id;
    @(posedge clk);
    while (busy) @(posedge clk);
    dispatch_step(row);
    if (row.typed) begin
      pending_beats.push_back(row.want);
    end else begin
      foreach (step_beats[k]) pending_beats.push_back(step_beats[k]);
    end
  endtask

  // hold off the sender until every owed beat has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  // result checker: outputs are sampled at the edge that ends the beat
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_strobe) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: kind %0d slot %0d runs %0d", out_kind, out_slot,
               out_runs);
        err_cnt++;
      end else begin
        want = pending_beats.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_kind);
          err_cnt++;
        end
        if (out_slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_slot);
          err_cnt++;
        end
        if (out_accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_accepted);
          err_cnt++;
        end
        if (out_runs !== want.runs) begin
          $error("runs: expected %0d, got %0d", want.runs, out_runs);
          err_cnt++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: cycles in which neither a command nor a result beat moves
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_strobe)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 18;
    foreach (DIRECTED[k]) issue_cmd(DIRECTED[k]);
    wait_drained();

    // random phases: light sender gaps, heavy gaps, then back to back
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 18 : (phase == 1) ? 55 : 0;
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        issue_cmd(random_row());
        if (k == RAND_PER_PHASE / 2) wait_drained();
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending_beats.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
